/* hw/rtl/hrss_pkg.sv */
// Shared constants, types and helpers for the history record start scanner.
// No dependencies; the RTL modules refer to it by scoped names.
package hrss_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int STAMP_BITS  = 48;
    localparam int CUTOFF_BITS = 48;
    localparam int OUT_OFS_BITS = 32;

    // configuration port
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam logic CFG_IDX_CUTOFF = 1'b0;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // stamp radix codes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // characters
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_W       = 8'h77;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [23:0] HEAD_DASHES = 24'h2D2D2D;
    localparam logic [23:0] HEAD_DOTS   = 24'h2E2E2E;

    typedef struct packed {
        logic [OUT_OFS_BITS-1:0] record_offset;
        logic                    scan_done;
        logic                    last_result;
    } res_t;

    // up to two results per request, in order: r0 first
    typedef struct packed {
        logic v0;
        res_t r0;
        logic v1;
        res_t r1;
    } push_t;

    function automatic logic [OUT_OFS_BITS-1:0] to_out_ofs(input logic [OFFSET_BITS-1:0] ofs);
        logic [63:0] wide;
        wide = 64'(ofs);
        return wide[OUT_OFS_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/hrss_req_if.sv */
// Request channel: one data byte or the end-of-region marker.
// Depends on nothing.
interface hrss_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, req_type, data_byte, input ready);
    modport sink   (input valid, req_type, data_byte, output ready);
endinterface

/* hw/rtl/hrss_res_if.sv */
// Result channel: record offset, end-of-scan flag and last-result flag.
// Depends on nothing.
interface hrss_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] record_offset;
    logic        scan_done;
    logic        last_result;

    modport source (output valid, record_offset, scan_done, last_result, input ready);
    modport sink   (input valid, record_offset, scan_done, last_result, output ready);
endinterface

/* hw/rtl/hrss_apb_regs.sv */
// APB register file holding the cutoff time.
// Depends on hrss_pkg.
module hrss_apb_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hrss_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [hrss_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [hrss_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output logic [hrss_pkg::CUTOFF_BITS-1:0]     cutoff_time
);

    logic [hrss_pkg::CUTOFF_BITS-1:0] cutoff_reg;
    logic                             reg_idx;
    logic                             wr_en;

    // registers sit at 8-byte strides
    assign reg_idx = paddr[3];
    assign wr_en   = psel && penable && pwrite && (reg_idx == hrss_pkg::CFG_IDX_CUTOFF);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
        end
        else if (wr_en)
        begin
            cutoff_reg <= pwdata[hrss_pkg::CUTOFF_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == hrss_pkg::CFG_IDX_CUTOFF)
        begin
            prdata = hrss_pkg::CFG_DATA_BITS'(cutoff_reg);
        end
    end

    assign cutoff_time = cutoff_reg;

endmodule

/* hw/rtl/hrss_res_queue.sv */
// Result queue: takes up to two results per cycle, hands out one.
// Depends on hrss_pkg.
module hrss_res_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hrss_pkg::push_t               push,
    output logic [hrss_pkg::QUEUE_CW-1:0] count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hrss_pkg::res_t                out_res
);

    hrss_pkg::res_t                mem [hrss_pkg::QUEUE_DEPTH];
    logic [hrss_pkg::QUEUE_AW-1:0] head_reg;
    logic [hrss_pkg::QUEUE_AW-1:0] tail_reg;
    logic [hrss_pkg::QUEUE_CW-1:0] count_reg;
    logic [hrss_pkg::QUEUE_AW-1:0] tail_p1;
    logic                          pop;
    logic [hrss_pkg::QUEUE_CW-1:0] n_push;

    assign pop     = out_valid && out_ready;
    assign tail_p1 = tail_reg + hrss_pkg::QUEUE_AW'(1);
    assign n_push  = hrss_pkg::QUEUE_CW'(push.v0) + hrss_pkg::QUEUE_CW'(push.v1);

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[tail_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[tail_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= head_reg + hrss_pkg::QUEUE_AW'(1);
            end
            tail_reg  <= tail_reg + n_push[hrss_pkg::QUEUE_AW-1:0];
            count_reg <= count_reg + n_push - hrss_pkg::QUEUE_CW'(pop);
        end
    end

    assign count     = count_reg;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[head_reg];

endmodule

/* hw/rtl/hrss_scan_core.sv */
// Input register, line/stamp state and per-byte scan logic.
// Depends on hrss_pkg; pushes results into hrss_res_queue.
module hrss_scan_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_req_type,
    input  logic [7:0]                        in_data_byte,
    input  logic [hrss_pkg::CUTOFF_BITS-1:0]  cutoff_time,
    input  logic [hrss_pkg::QUEUE_CW-1:0]     queue_count,
    output hrss_pkg::push_t                   push
);

    localparam int OB = hrss_pkg::OFFSET_BITS;
    localparam int SB = hrss_pkg::STAMP_BITS;
    localparam int CMPW = (SB > hrss_pkg::CUTOFF_BITS) ? SB : hrss_pkg::CUTOFF_BITS;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_KEY_H   = 4'd1,
        PH_KEY_E   = 4'd2,
        PH_KEY_N   = 4'd3,
        PH_KEY_COL = 4'd4,
        PH_GAP     = 4'd5,
        PH_ZERO    = 4'd6,
        PH_HEXMARK = 4'd7,
        PH_DIGITS  = 4'd8,
        PH_DONE    = 4'd9,
        PH_FAIL    = 4'd10
    } phase_t;

    // input stage
    logic       stg_valid_reg;
    logic       stg_type_reg;
    logic [7:0] stg_byte_reg;

    // scan state
    logic [OB-1:0] byte_pos_reg,   byte_pos_next;
    logic [OB-1:0] row_start_reg,  row_start_next;
    logic [1:0]    row_len_reg,    row_len_next;
    logic [23:0]   line_head_reg,  line_head_next;
    logic          pend_reg,       pend_next;
    logic [OB-1:0] pend_ofs_reg,   pend_ofs_next;
    phase_t        phase_reg,      phase_next;
    logic [1:0]    radix_reg,      radix_next;
    logic [SB-1:0] value_reg,      value_next;

    logic          accept;
    logic [hrss_pkg::QUEUE_CW:0] space_need;

    logic [7:0]    c;
    logic [OB-1:0] pos_p1;
    logic          is_dec, is_lo, is_up;
    logic [3:0]    dec_val, hex_val;
    logic          hex_ok;
    logic          dig_ok;
    logic [3:0]    dig_val;
    logic [SB+3:0] acc_prod;
    logic [SB+3:0] acc_sum;
    logic [SB-1:0] acc_val;
    logic          space_led;
    logic          stamp_ok;
    logic          below_cutoff;
    logic          is_start;
    logic          e0_v, e1_v;
    logic [OB-1:0] e0_ofs, e1_ofs;
    logic          e1_done;

    // worst case: the staged request and the incoming one each give two results
    assign space_need = (hrss_pkg::QUEUE_CW+1)'(queue_count)
                      + (stg_valid_reg ? (hrss_pkg::QUEUE_CW+1)'(2) : '0);
    assign in_ready   = (space_need <= (hrss_pkg::QUEUE_CW+1)'(hrss_pkg::QUEUE_DEPTH - 2));
    assign accept     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_type_reg <= in_req_type;
            stg_byte_reg <= in_data_byte;
        end
    end

    // digit decode
    assign c       = stg_byte_reg;
    assign pos_p1  = byte_pos_reg + OB'(1);
    assign is_dec  = (c >= hrss_pkg::CH_0) && (c <= hrss_pkg::CH_9);
    assign is_lo   = (c >= hrss_pkg::CH_LO_A) && (c <= hrss_pkg::CH_LO_F);
    assign is_up   = (c >= hrss_pkg::CH_UP_A) && (c <= hrss_pkg::CH_UP_F);
    assign dec_val = 4'(c - hrss_pkg::CH_0);
    assign hex_ok  = is_dec || is_lo || is_up;

    always_comb
    begin
        if (is_dec)
        begin
            hex_val = dec_val;
        end
        else if (is_lo)
        begin
            hex_val = 4'(c - hrss_pkg::CH_LO_A + 8'd10);
        end
        else
        begin
            hex_val = 4'(c - hrss_pkg::CH_UP_A + 8'd10);
        end
    end

    // digit of the current radix and saturating accumulate
    always_comb
    begin
        dig_val  = dec_val;
        acc_prod = '0;
        case (radix_reg)
            hrss_pkg::RADIX_DEC:
            begin
                dig_ok   = is_dec;
                acc_prod = ((SB+4)'(value_reg) << 3) + ((SB+4)'(value_reg) << 1);
            end
            hrss_pkg::RADIX_OCT:
            begin
                dig_ok   = is_dec && (c <= hrss_pkg::CH_7);
                acc_prod = (SB+4)'(value_reg) << 3;
            end
            hrss_pkg::RADIX_HEX:
            begin
                dig_ok   = hex_ok;
                dig_val  = hex_val;
                acc_prod = (SB+4)'(value_reg) << 4;
            end
            default:
            begin
                dig_ok = 1'b0;
            end
        endcase
        acc_sum = acc_prod + (SB+4)'(dig_val);
        if (acc_sum[SB+3:SB] != 4'd0)
        begin
            acc_val = '1;
        end
        else
        begin
            acc_val = acc_sum[SB-1:0];
        end
    end

    assign space_led    = (row_len_reg != 2'd0) && (line_head_reg[7:0] == hrss_pkg::CH_SPACE);
    assign stamp_ok     = ((phase_reg == PH_DIGITS) || (phase_reg == PH_DONE))
                        && (value_reg != '0);
    assign below_cutoff = (CMPW'(value_reg) < CMPW'(cutoff_time));
    assign is_start     = (row_len_reg == 2'd3)
                        && (line_head_reg[7:0] != hrss_pkg::CH_PERCENT)
                        && (line_head_reg != hrss_pkg::HEAD_DASHES)
                        && (line_head_reg != hrss_pkg::HEAD_DOTS);

    always_comb
    begin
        logic [23:0] head_tmp;

        head_tmp        = line_head_reg;
        byte_pos_next   = byte_pos_reg;
        row_start_next  = row_start_reg;
        row_len_next    = row_len_reg;
        line_head_next  = line_head_reg;
        pend_next       = pend_reg;
        pend_ofs_next   = pend_ofs_reg;
        phase_next      = phase_reg;
        radix_next      = radix_reg;
        value_next      = value_reg;
        e0_v            = 1'b0;
        e0_ofs          = pend_ofs_reg;
        e1_v            = 1'b0;
        e1_ofs          = row_start_reg;
        e1_done         = 1'b0;

        if (stg_valid_reg)
        begin
            if (stg_type_reg == hrss_pkg::REQ_END)
            begin
                e0_v            = pend_reg;
                e1_v            = 1'b1;
                e1_ofs          = '0;
                e1_done         = 1'b1;
                byte_pos_next   = '0;
                row_start_next  = '0;
                row_len_next    = '0;
                line_head_next  = '0;
                pend_next       = 1'b0;
                phase_next      = PH_LEAD;
                radix_next      = hrss_pkg::RADIX_DEC;
                value_next      = '0;
            end
            else if (c == hrss_pkg::CH_NL)
            begin
                if (space_led)
                begin
                    if (pend_reg && stamp_ok)
                    begin
                        pend_next = 1'b0;
                        e0_v      = (cutoff_time == '0) || below_cutoff;
                    end
                end
                else
                begin
                    e0_v = pend_reg;
                    pend_next = 1'b0;
                    if (is_start)
                    begin
                        if (cutoff_time != '0)
                        begin
                            pend_next     = 1'b1;
                            pend_ofs_next = row_start_reg;
                        end
                        else
                        begin
                            e1_v = 1'b1;
                        end
                    end
                end
                row_start_next  = pos_p1;
                row_len_next    = '0;
                line_head_next  = '0;
                phase_next      = PH_LEAD;
                radix_next      = hrss_pkg::RADIX_DEC;
                value_next      = '0;
                byte_pos_next   = pos_p1;
            end
            else
            begin
                if (row_len_reg != 2'd3)
                begin
                    case (row_len_reg)
                        2'd0:    head_tmp[7:0]   = c;
                        2'd1:    head_tmp[15:8]  = c;
                        default: head_tmp[23:16] = c;
                    endcase
                    row_len_next = row_len_reg + 2'd1;
                end
                line_head_next = head_tmp;
                byte_pos_next  = pos_p1;

                if (head_tmp[7:0] == hrss_pkg::CH_SPACE)
                begin
                    case (phase_reg)
                        PH_LEAD:
                        begin
                            if (c == hrss_pkg::CH_W)
                            begin
                                phase_next = PH_KEY_H;
                            end
                            else if (c != hrss_pkg::CH_SPACE)
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_KEY_H:
                        begin
                            phase_next = (c == hrss_pkg::CH_H) ? PH_KEY_E : PH_FAIL;
                        end
                        PH_KEY_E:
                        begin
                            phase_next = (c == hrss_pkg::CH_E) ? PH_KEY_N : PH_FAIL;
                        end
                        PH_KEY_N:
                        begin
                            phase_next = (c == hrss_pkg::CH_N) ? PH_KEY_COL : PH_FAIL;
                        end
                        PH_KEY_COL:
                        begin
                            phase_next = (c == hrss_pkg::CH_COLON) ? PH_GAP : PH_FAIL;
                        end
                        PH_GAP:
                        begin
                            if (c == hrss_pkg::CH_0)
                            begin
                                value_next = '0;
                                phase_next = PH_ZERO;
                            end
                            else if ((c >= hrss_pkg::CH_1) && (c <= hrss_pkg::CH_9))
                            begin
                                radix_next = hrss_pkg::RADIX_DEC;
                                value_next = SB'(dec_val);
                                phase_next = PH_DIGITS;
                            end
                            else if (c != hrss_pkg::CH_SPACE)
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_ZERO:
                        begin
                            if ((c == hrss_pkg::CH_LO_X) || (c == hrss_pkg::CH_UP_X))
                            begin
                                radix_next = hrss_pkg::RADIX_HEX;
                                phase_next = PH_HEXMARK;
                            end
                            else if (is_dec && (c <= hrss_pkg::CH_7))
                            begin
                                radix_next = hrss_pkg::RADIX_OCT;
                                value_next = SB'(dec_val);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_HEXMARK:
                        begin
                            if (hex_ok)
                            begin
                                value_next = SB'(hex_val);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (dig_ok)
                            begin
                                value_next = acc_val;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            row_start_reg  <= '0;
            row_len_reg    <= '0;
            line_head_reg  <= '0;
            pend_reg       <= 1'b0;
            phase_reg      <= PH_LEAD;
            radix_reg      <= hrss_pkg::RADIX_DEC;
            value_reg      <= '0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            row_start_reg  <= row_start_next;
            row_len_reg    <= row_len_next;
            line_head_reg  <= line_head_next;
            pend_reg       <= pend_next;
            phase_reg      <= phase_next;
            radix_reg      <= radix_next;
            value_reg      <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ofs_reg <= pend_ofs_next;
    end

    // pack results in order, first one always in slot 0
    always_comb
    begin
        push = '0;
        if (e0_v)
        begin
            push.v0               = 1'b1;
            push.r0.record_offset = hrss_pkg::to_out_ofs(e0_ofs);
            push.r0.scan_done     = 1'b0;
            push.r0.last_result   = !e1_v;
            push.v1               = e1_v;
            push.r1.record_offset = hrss_pkg::to_out_ofs(e1_ofs);
            push.r1.scan_done     = e1_done;
            push.r1.last_result   = 1'b1;
        end
        else if (e1_v)
        begin
            push.v0               = 1'b1;
            push.r0.record_offset = hrss_pkg::to_out_ofs(e1_ofs);
            push.r0.scan_done     = e1_done;
            push.r0.last_result   = 1'b1;
        end
    end

endmodule

/* hw/rtl/history_record_start_scanner_top.sv */
// A request is registered in an input stage; its results are then written into
// the result queue, whose head drives the result channel.
// Throughput: one request per cycle; the result queue (8 entries) throttles
// requests when the downstream side stalls or requests yield two results.
// Reset (rst_n, async, active low): scan state cleared, offset 0, no pending
// record, queue empty, cutoff_time 0. Depends on hrss_pkg, both interfaces.
module history_record_start_scanner_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    hrss_req_if.sink                           req_ch,
    hrss_res_if.source                         res_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hrss_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [hrss_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [hrss_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    logic [hrss_pkg::CUTOFF_BITS-1:0] cutoff_time;
    logic [hrss_pkg::QUEUE_CW-1:0]    queue_count;
    hrss_pkg::push_t                  push;
    hrss_pkg::res_t                   out_res;

    hrss_apb_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cutoff_time (cutoff_time)
    );

    hrss_scan_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req_ch.valid),
        .in_ready     (req_ch.ready),
        .in_req_type  (req_ch.req_type),
        .in_data_byte (req_ch.data_byte),
        .cutoff_time  (cutoff_time),
        .queue_count  (queue_count),
        .push         (push)
    );

    hrss_res_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .count     (queue_count),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .out_res   (out_res)
    );

    assign res_ch.record_offset = out_res.record_offset;
    assign res_ch.scan_done     = out_res.scan_done;
    assign res_ch.last_result   = out_res.last_result;

endmodule
